/* hdl/baro_pkg.sv */
package baro_pkg;

	localparam int RAW_W    = 24;
	localparam int COEF_W   = 16;
	localparam int DT_W     = 25;
	localparam int TPROD_W  = 42;
	localparam int TEMP_W   = 19;
	localparam int PRESS_W  = 23;
	localparam int SENS_W   = 36;
	localparam int OFF_W    = 37;
	localparam int SLO_W    = 18;
	localparam int SHI_W    = SENS_W - SLO_W;
	localparam int PLO_W    = RAW_W + SLO_W;
	localparam int PHI_W    = RAW_W + 1 + SHI_W;
	localparam int PROD_W   = 62;
	localparam int DIFF_W   = 42;
	localparam int PSHR_W   = DIFF_W - 15;

	localparam int TEMP_SHIFT    = 23;
	localparam int OFF_SCALE     = 17;
	localparam int OFF_TC_SHIFT  = 6;
	localparam int SENS_SCALE    = 16;
	localparam int SENS_TC_SHIFT = 7;
	localparam int PROD_SHIFT    = 21;
	localparam int PRESS_SHIFT   = 15;

	localparam logic signed [TEMP_W:0] TEMP_BASE = 20'sd2000;

	localparam logic signed [PSHR_W-1:0] PRESS_MIN = -27'sd4194304;
	localparam logic signed [PSHR_W-1:0] PRESS_MAX = 27'sd4194303;

	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_SENS_COEFF    = 3'd0;
	localparam logic [2:0] REG_OFFSET_COEFF  = 3'd1;
	localparam logic [2:0] REG_SENS_TEMPCO   = 3'd2;
	localparam logic [2:0] REG_OFFSET_TEMPCO = 3'd3;
	localparam logic [2:0] REG_REF_TEMP      = 3'd4;
	localparam logic [2:0] REG_TEMP_TEMPCO   = 3'd5;

	// compensated terms handed from the front end to the pressure back end
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic signed [SENS_W-1:0] sens;
		logic signed [OFF_W-1:0]  off;
		logic [RAW_W-1:0]         press;
	} comp_t;

endpackage

/* hdl/baro_press.sv */
module baro_press (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_s3,
	input  baro_pkg::comp_t                     comp_s3,
	output logic                                done,
	output logic signed [baro_pkg::TEMP_W-1:0]  temp_centi,
	output logic signed [baro_pkg::PRESS_W-1:0] press_centi
);
	import baro_pkg::*;

	logic                      valid_s4;
	logic signed [PHI_W-1:0]   phi_s4;
	logic [PLO_W-1:0]          plo_s4;
	logic signed [OFF_W-1:0]   off_s4;
	logic signed [TEMP_W-1:0]  temp_s4;

	logic                      valid_s5;
	logic signed [PROD_W-1:0]  prod_s5;
	logic signed [OFF_W-1:0]   off_s5;
	logic signed [TEMP_W-1:0]  temp_s5;

	logic signed [PHI_W-1:0]   phi;
	logic [PLO_W-1:0]          plo;
	logic signed [PROD_W-1:0]  prod;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [PSHR_W-1:0]  pshr;
	logic signed [PRESS_W-1:0] psat;

	// sens split into signed high and unsigned low halves, two narrow multipliers
	assign phi = $signed({1'b0, comp_s3.press}) * $signed(comp_s3.sens[SENS_W-1:SLO_W]);
	assign plo = comp_s3.press * comp_s3.sens[SLO_W-1:0];

	assign prod = $signed({phi_s4[PHI_W-1], phi_s4, {SLO_W{1'b0}}})
		+ $signed({{(PROD_W-PLO_W){1'b0}}, plo_s4});

	assign diff = $signed({prod_s5[PROD_W-1], prod_s5[PROD_W-1:PROD_SHIFT]})
		- $signed({{(DIFF_W-OFF_W){off_s5[OFF_W-1]}}, off_s5});
	assign pshr = diff[DIFF_W-1:PRESS_SHIFT];

	always_comb begin
		if (pshr < PRESS_MIN) begin
			psat = PRESS_MIN[PRESS_W-1:0];
		end else if (pshr > PRESS_MAX) begin
			psat = PRESS_MAX[PRESS_W-1:0];
		end else begin
			psat = pshr[PRESS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			done     <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		phi_s4      <= phi;
		plo_s4      <= plo;
		off_s4      <= comp_s3.off;
		temp_s4     <= comp_s3.temp;
		prod_s5     <= prod;
		off_s5      <= off_s4;
		temp_s5     <= temp_s4;
		temp_centi  <= temp_s5;
		press_centi <= psat;
	end

endmodule

/* hdl/baro_sensor_compensation.sv */
// Each beat taken on start passes through registers s1, s2, s3, s4 and s5 to its
// result, which is strobed by done for one cycle.
// Throughput: one beat per cycle; busy stays low, the six-stage pipeline has no stall.
// The receiver cannot stall, so results are never held back.
// Reset (arst_n low) clears all calibration registers and every pipeline valid bit.
module baro_sensor_compensation (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [baro_pkg::RAW_W-1:0]          raw_temp,
	input  logic [baro_pkg::RAW_W-1:0]          raw_press,
	output logic                                done,
	output logic signed [baro_pkg::TEMP_W-1:0]  temp_centi,
	output logic signed [baro_pkg::PRESS_W-1:0] press_centi,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [baro_pkg::ADDR_W-1:0]         paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import baro_pkg::*;

	logic [COEF_W-1:0] sens_coeff_q;
	logic [COEF_W-1:0] offset_coeff_q;
	logic [COEF_W-1:0] sens_tempco_q;
	logic [COEF_W-1:0] offset_tempco_q;
	logic [COEF_W-1:0] ref_temp_q;
	logic [COEF_W-1:0] temp_tempco_q;

	logic [2:0]        reg_idx;
	logic              wr_en;
	logic [COEF_W-1:0] rd_val;

	logic                       valid_s1;
	logic signed [DT_W-1:0]     dt_s1;
	logic [RAW_W-1:0]           press_s1;
	logic                       valid_s2;
	logic signed [TPROD_W-1:0]  tp_s2;
	logic signed [TPROD_W-1:0]  op_s2;
	logic signed [TPROD_W-1:0]  sp_s2;
	logic [RAW_W-1:0]           press_s2;
	logic                       valid_s3;
	comp_t                      comp_s3;

	logic signed [DT_W-1:0]     dt;
	logic signed [TPROD_W-1:0]  tp;
	logic signed [TPROD_W-1:0]  op;
	logic signed [TPROD_W-1:0]  sp;
	logic signed [TEMP_W:0]     temp_sum;
	comp_t                      comp;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	// register file
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_coeff_q    <= '0;
			offset_coeff_q  <= '0;
			sens_tempco_q   <= '0;
			offset_tempco_q <= '0;
			ref_temp_q      <= '0;
			temp_tempco_q   <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SENS_COEFF:    sens_coeff_q    <= pwdata[COEF_W-1:0];
				REG_OFFSET_COEFF:  offset_coeff_q  <= pwdata[COEF_W-1:0];
				REG_SENS_TEMPCO:   sens_tempco_q   <= pwdata[COEF_W-1:0];
				REG_OFFSET_TEMPCO: offset_tempco_q <= pwdata[COEF_W-1:0];
				REG_REF_TEMP:      ref_temp_q      <= pwdata[COEF_W-1:0];
				REG_TEMP_TEMPCO:   temp_tempco_q   <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SENS_COEFF:    rd_val = sens_coeff_q;
			REG_OFFSET_COEFF:  rd_val = offset_coeff_q;
			REG_SENS_TEMPCO:   rd_val = sens_tempco_q;
			REG_OFFSET_TEMPCO: rd_val = offset_tempco_q;
			REG_REF_TEMP:      rd_val = ref_temp_q;
			REG_TEMP_TEMPCO:   rd_val = temp_tempco_q;
			default:           rd_val = '0;
		endcase
	end

	assign prdata = {{(32-COEF_W){1'b0}}, rd_val};

	// s1: signed temperature difference
	assign dt = $signed({1'b0, raw_temp}) - $signed({1'b0, ref_temp_q, 8'b0});

	// s2: the three dT products
	assign tp = dt_s1 * $signed({1'b0, temp_tempco_q});
	assign op = dt_s1 * $signed({1'b0, offset_tempco_q});
	assign sp = dt_s1 * $signed({1'b0, sens_tempco_q});

	// s3: scale and add the calibration terms, shifts are floor
	assign temp_sum = $signed({tp_s2[TPROD_W-1], tp_s2[TPROD_W-1:TEMP_SHIFT]}) + TEMP_BASE;

	always_comb begin
		comp.temp  = temp_sum[TEMP_W-1:0];
		comp.off   = $signed({{(OFF_W-COEF_W-OFF_SCALE){1'b0}}, offset_coeff_q,
			{OFF_SCALE{1'b0}}})
			+ $signed({{(OFF_W-TPROD_W+OFF_TC_SHIFT){op_s2[TPROD_W-1]}},
			op_s2[TPROD_W-1:OFF_TC_SHIFT]});
		comp.sens  = $signed({{(SENS_W-COEF_W-SENS_SCALE){1'b0}}, sens_coeff_q,
			{SENS_SCALE{1'b0}}})
			+ $signed({{(SENS_W-TPROD_W+SENS_TC_SHIFT){sp_s2[TPROD_W-1]}},
			sp_s2[TPROD_W-1:SENS_TC_SHIFT]});
		comp.press = press_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		dt_s1    <= dt;
		press_s1 <= raw_press;
		tp_s2    <= tp;
		op_s2    <= op;
		sp_s2    <= sp;
		press_s2 <= press_s1;
		comp_s3  <= comp;
	end

	baro_press u_press (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s3    (valid_s3),
		.comp_s3     (comp_s3),
		.done        (done),
		.temp_centi  (temp_centi),
		.press_centi (press_centi)
	);

	a_beat_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##6 done)
		else $error("accepted beat produced no result");

	a_result_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 6))
		else $error("result without an accepted beat");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (temp_sum >= -20'sd129072) && (temp_sum <= 20'sd133071))
		else $error("temperature out of its possible range");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import baro_pkg::*;

	localparam int PIPE_LAT     = 6;
	localparam int NUM_CAL_REGS = 6;
	localparam int RAW_MAX      = (1 << RAW_W) - 1;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		logic [RAW_W-1:0] tval;
		logic [RAW_W-1:0] pval;
	} conv_t;

	typedef struct {
		logic signed [TEMP_W-1:0]  temp;
		logic signed [PRESS_W-1:0] press;
	} reading_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      start       = 1'b0;
	logic [RAW_W-1:0]          raw_temp    = '0;
	logic [RAW_W-1:0]          raw_press   = '0;
	logic                      psel        = 1'b0;
	logic                      penable     = 1'b0;
	logic                      pwrite      = 1'b0;
	logic [ADDR_W-1:0]         paddr       = '0;
	logic [31:0]               pwdata      = '0;
	logic                      busy;
	logic                      done;
	logic signed [TEMP_W-1:0]  temp_centi;
	logic signed [PRESS_W-1:0] press_centi;
	logic [31:0]               prdata;
	logic                      pready;

	logic [15:0] cal_word [NUM_CAL_REGS];
	conv_t       conv_q[$];
	reading_t    comp_due_q[$];
	int          gap_left    = 0;
	bit          idle_on     = 1'b1;
	int          err_count   = 0;
	int          cycle_count = 0;

	baro_sensor_compensation u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.raw_temp    (raw_temp),
		.raw_press   (raw_press),
		.done        (done),
		.temp_centi  (temp_centi),
		.press_centi (press_centi),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// first-order compensation, exact 64-bit signed math, >>> floors
	function automatic reading_t compensate(logic [RAW_W-1:0] t_raw, logic [RAW_W-1:0] p_raw);
		longint signed d1, d2, dt, temp, off, sens, p;
		reading_t r;
		d1   = longint'(p_raw);
		d2   = longint'(t_raw);
		dt   = d2 - longint'(cal_word[REG_REF_TEMP]) * 256;
		temp = longint'(TEMP_BASE) + ((dt * longint'(cal_word[REG_TEMP_TEMPCO])) >>> TEMP_SHIFT);
		off  = (longint'(cal_word[REG_OFFSET_COEFF]) <<< OFF_SCALE)
		     + ((longint'(cal_word[REG_OFFSET_TEMPCO]) * dt) >>> OFF_TC_SHIFT);
		sens = (longint'(cal_word[REG_SENS_COEFF]) <<< SENS_SCALE)
		     + ((longint'(cal_word[REG_SENS_TEMPCO]) * dt) >>> SENS_TC_SHIFT);
		p    = (((d1 * sens) >>> PROD_SHIFT) - off) >>> PRESS_SHIFT;
		if (p < longint'(PRESS_MIN))
			p = longint'(PRESS_MIN);
		if (p > longint'(PRESS_MAX))
			p = longint'(PRESS_MAX);
		r.temp  = temp[TEMP_W-1:0];
		r.press = p[PRESS_W-1:0];
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_count++;
	endtask

	// APB write: setup, access, done when pready seen with penable
	task automatic cal_write(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx < NUM_CAL_REGS)
			cal_word[idx] = value[15:0];
	endtask

	task automatic queue_conv(input int t, input int p);
		conv_t c;
		c.tval = RAW_W'(t);
		c.pval = RAW_W'(p);
		conv_q.push_back(c);
	endtask

	// hold the sender until every queued beat has come back, then let the pipe settle
	task automatic wait_idle();
		do @(negedge clk); while (conv_q.size() != 0 || start || comp_due_q.size() != 0);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// driver
	always @(posedge clk) begin
		conv_t nxt;
		if (!arst_n) begin
			start    <= 1'b0;
			gap_left <= 0;
		end else if (!(start && busy)) begin
			if (start)
				comp_due_q.push_back(compensate(raw_temp, raw_press));
			if (gap_left > 0) begin
				start    <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (conv_q.size() != 0) begin
				nxt       = conv_q.pop_front();
				start     <= 1'b1;
				raw_temp  <= nxt.tval;
				raw_press <= nxt.pval;
				if (idle_on && $urandom_range(0, 5) == 0)
					gap_left <= $urandom_range(1, 8);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && done !== 1'b0) begin
			if (comp_due_q.size() == 0) begin
				flag_mismatch("result beat with nothing outstanding");
			end else begin
				want = comp_due_q.pop_front();
				if (temp_centi !== want.temp)
					flag_mismatch($sformatf("temp_centi got %0d want %0d",
						temp_centi, want.temp));
				if (press_centi !== want.press)
					flag_mismatch($sformatf("press_centi got %0d want %0d",
						press_centi, want.press));
			end
		end
	end

	initial begin
		int ref_raw;
		int t;
		int mode;
		logic [15:0] w;
		int pr;

		cal_word = '{default: '0};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// calibration left at reset: all zero
		queue_conv('0, '0);
		queue_conv(RAW_MAX, RAW_MAX);
		queue_conv(RAW_MAX, '0);
		queue_conv('0, RAW_MAX);
		wait_idle();

		// typical factory words; junk in the upper data bits must be dropped
		cal_write(REG_SENS_COEFF,    32'hA5A5_0000 | 32'd46372);
		cal_write(REG_OFFSET_COEFF,  32'hFFFF_0000 | 32'd43981);
		cal_write(REG_SENS_TEMPCO,   32'd29059);
		cal_write(REG_OFFSET_TEMPCO, 32'd27842);
		cal_write(REG_REF_TEMP,      32'd31553);
		cal_write(REG_TEMP_TEMPCO,   32'd28165);
		// nonexistent registers, writes ignored
		cal_write(3'(NUM_CAL_REGS),     $urandom);
		cal_write(3'(NUM_CAL_REGS + 1), $urandom);
		ref_raw = int'(cal_word[REG_REF_TEMP]) * 256;
		queue_conv(8077636, 6465444);
		queue_conv(ref_raw, 6465444);
		queue_conv(ref_raw - 1, 6465444);
		queue_conv(ref_raw + 1, RAW_MAX);
		queue_conv('0, RAW_MAX);
		queue_conv(RAW_MAX, RAW_MAX);
		queue_conv('0, '0);
		wait_idle();

		// every word at full scale
		for (int i = 0; i < NUM_CAL_REGS; i++)
			cal_write(3'(i), 32'h0000_FFFF);
		queue_conv('0, '0);
		queue_conv('0, RAW_MAX);
		queue_conv(RAW_MAX, '0);
		queue_conv(RAW_MAX, RAW_MAX);
		queue_conv(RAW_MAX - 255, $urandom);
		wait_idle();

		// reference at zero so dT reaches its positive end
		cal_write(REG_REF_TEMP, 32'd0);
		queue_conv(RAW_MAX, RAW_MAX);
		queue_conv('0, RAW_MAX);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			for (int i = 0; i < NUM_CAL_REGS; i++) begin
				mode = $urandom_range(0, 5);
				w = (mode == 0) ? 16'h0000 : (mode == 1) ? 16'hFFFF : 16'($urandom);
				cal_write(3'(i), {16'($urandom), w});
			end
			if ($urandom_range(0, 2) == 0)
				cal_write(3'($urandom_range(NUM_CAL_REGS, NUM_CAL_REGS + 1)), $urandom);
			idle_on = (ph != 7);
			ref_raw = int'(cal_word[REG_REF_TEMP]) * 256;
			for (int n = 0; n < 80; n++) begin
				mode = $urandom_range(0, 9);
				if (mode == 0) begin
					t = $urandom_range(0, 1) ? RAW_MAX : 0;
				end else if (mode <= 2) begin
					// dT small and of either sign: rounding of negative products
					t = ref_raw + int'($urandom_range(0, 64)) - 32;
					if (t < 0)
						t = 0;
					if (t > RAW_MAX)
						t = RAW_MAX;
				end else begin
					t = $urandom_range(0, RAW_MAX);
				end
				if ($urandom_range(0, 9) == 0)
					pr = $urandom_range(0, 1) ? RAW_MAX : 0;
				else
					pr = $urandom_range(0, RAW_MAX);
				queue_conv(t, pr);
			end
			wait_idle();
		end

		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* files.f */
hdl/baro_pkg.sv
hdl/baro_press.sv
hdl/baro_sensor_compensation.sv
bench/testbench.sv
